// File: src/bgi_pkg.sv
// bgi_pkg: shared widths, command and register codes, and transaction types
// for the bilinear grid interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

    // fixed field widths
    localparam int X_POS_W     = 17;
    localparam int Y_POS_W     = 16;
    localparam int COL_W       = 9;
    localparam int ROW_W       = 8;
    localparam int SAMPLE_W    = 32;
    localparam int GRID_W_W    = 10;
    localparam int GRID_H_W    = 9;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 1;

    // internal operation widths, sized for the largest supported grid and fraction
    localparam int IDX_W       = 12;
    localparam int FRAC_W      = 17;

    // queue between front and back
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // result buffer in the back end
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = 3;
    localparam int OUT_CNT_W   = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [X_POS_W-1:0]  x_pos;
        logic [Y_POS_W-1:0]  y_pos;
        logic [COL_W-1:0]    write_col;
        logic [ROW_W-1:0]    write_row;
        logic [SAMPLE_W-1:0] sample_value;
    } bgi_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] interp_value;
        logic                edge_clamped;
    } bgi_rsp_t;

    // classified operation: a query carries its right/lower neighbor indices and
    // weights, a write carries its grid position
    typedef struct packed {
        logic                is_query;
        logic [IDX_W-1:0]    col_idx;
        logic [IDX_W-1:0]    row_idx;
        logic [FRAC_W-1:0]   col_frac;
        logic [FRAC_W-1:0]   row_frac;
        logic                clamped;
        logic [SAMPLE_W-1:0] sample_value;
    } bgi_op_t;

endpackage

`default_nettype wire

// File: src/bgi_front.sv
// bgi_front: accepts request transactions, drops writes outside the store,
// splits and clamps query coordinates into neighbor indices and weights
// depends on bgi_pkg
`timescale 1ns / 1ps
`default_nettype none

module bgi_front
    import bgi_pkg::*;
#(
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [GRID_W_W-1:0] grid_width,
    input  wire logic [GRID_H_W-1:0] grid_height,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire bgi_req_t            req,
    output logic                     op_valid,
    input  wire logic                op_ready,
    output bgi_op_t                  op
);

    localparam logic [X_POS_W-1:0] X_LIMIT     = X_POS_W'(MAX_COLS);
    localparam logic [Y_POS_W-1:0] Y_LIMIT     = Y_POS_W'(MAX_ROWS);
    localparam logic [X_POS_W-1:0] X_FRAC_MASK = X_POS_W'(2**FRAC_BITS - 1);
    localparam logic [Y_POS_W-1:0] Y_FRAC_MASK = Y_POS_W'(2**FRAC_BITS - 1);
    localparam logic [FRAC_W-1:0]  FRAC_ONE    = FRAC_W'(2**FRAC_BITS);

    logic               op_valid_reg;
    bgi_op_t            op_reg;
    bgi_op_t            op_next;
    logic               keep;
    logic [X_POS_W-1:0] nx;
    logic [X_POS_W-1:0] ix;
    logic [FRAC_W-1:0]  tx;
    logic               clamp_x;
    logic [Y_POS_W-1:0] ny;
    logic [Y_POS_W-1:0] iy;
    logic [FRAC_W-1:0]  ty;
    logic               clamp_y;

    // column axis
    always_comb
    begin
        nx = X_POS_W'(grid_width);
        if (nx < X_POS_W'(2))
        begin
            nx = X_POS_W'(2);
        end
        else if (nx > X_LIMIT)
        begin
            nx = X_LIMIT;
        end
        ix      = req.x_pos >> FRAC_BITS;
        tx      = FRAC_W'(req.x_pos & X_FRAC_MASK);
        clamp_x = 1'b0;
        if (ix >= nx)
        begin
            ix      = nx - X_POS_W'(1);
            tx      = FRAC_ONE;
            clamp_x = 1'b1;
        end
        else if (ix == '0)
        begin
            // below the first pixel center: pin to the first cell
            ix      = X_POS_W'(1);
            tx      = '0;
            clamp_x = 1'b1;
        end
    end

    // row axis
    always_comb
    begin
        ny = Y_POS_W'(grid_height);
        if (ny < Y_POS_W'(2))
        begin
            ny = Y_POS_W'(2);
        end
        else if (ny > Y_LIMIT)
        begin
            ny = Y_LIMIT;
        end
        iy      = req.y_pos >> FRAC_BITS;
        ty      = FRAC_W'(req.y_pos & Y_FRAC_MASK);
        clamp_y = 1'b0;
        if (iy >= ny)
        begin
            iy      = ny - Y_POS_W'(1);
            ty      = FRAC_ONE;
            clamp_y = 1'b1;
        end
        else if (iy == '0)
        begin
            iy      = Y_POS_W'(1);
            ty      = '0;
            clamp_y = 1'b1;
        end
    end

    always_comb
    begin
        op_next              = '0;
        op_next.sample_value = req.sample_value;
        if (req.cmd == CMD_QUERY)
        begin
            op_next.is_query = 1'b1;
            op_next.col_idx  = IDX_W'(ix);
            op_next.row_idx  = IDX_W'(iy);
            op_next.col_frac = tx;
            op_next.row_frac = ty;
            op_next.clamped  = clamp_x | clamp_y;
            keep             = 1'b1;
        end
        else
        begin
            op_next.is_query = 1'b0;
            op_next.col_idx  = IDX_W'(req.write_col);
            op_next.row_idx  = IDX_W'(req.write_row);
            keep = (32'(req.write_col) < 32'(MAX_COLS)) && (32'(req.write_row) < 32'(MAX_ROWS));
        end
    end

    assign req_ready = !op_valid_reg || op_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            op_valid_reg <= req_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            op_reg <= op_next;
        end
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

`default_nettype wire

// File: src/bgi_queue.sv
// bgi_queue: short fifo of classified operations between front and back
// depends on bgi_pkg
`timescale 1ns / 1ps
`default_nettype none

module bgi_queue
    import bgi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    output logic         push_ready,
    input  wire bgi_op_t push_op,
    output logic         pop_valid,
    input  wire logic    pop_ready,
    output bgi_op_t      pop_op
);

    bgi_op_t              q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = count_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = q_mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: src/bgi_back.sv
// bgi_back: four banked sample stores, bilinear blend pipeline and result buffer
// banks are split by column and row parity so a query reads one entry per bank
// depends on bgi_pkg
`timescale 1ns / 1ps
`default_nettype none

module bgi_back
    import bgi_pkg::*;
#(
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    op_valid,
    output logic         op_ready,
    input  wire bgi_op_t op,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output bgi_rsp_t     rsp
);

    localparam int BANK_COLS  = (MAX_COLS + 1) / 2;
    localparam int BANK_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int PROD_W     = SAMPLE_W + WT_W;
    localparam int SUM_W      = PROD_W + 1;

    localparam logic [WT_W-1:0]  WT_ONE     = WT_W'(2**FRAC_BITS);
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(2**(FRAC_BITS - 1));

    logic                 pop;
    logic [IDX_W-1:0]     even_col;
    logic [IDX_W-1:0]     odd_col;
    logic [IDX_W-1:0]     even_row;
    logic [IDX_W-1:0]     odd_row;
    logic [1:0]           wr_bank;
    logic [SAMPLE_W-1:0]  rd_data [4];

    logic [OUT_CNT_W-1:0] pending_reg;
    logic [OUT_CNT_W-1:0] pending_next;

    // stage 1: bank read data and query weights
    logic                 s1_valid_reg;
    logic                 s1_col_par_reg;
    logic                 s1_row_par_reg;
    logic [WT_W-1:0]      s1_t_reg;
    logic [WT_W-1:0]      s1_u_reg;
    logic                 s1_clamped_reg;
    logic [SAMPLE_W-1:0]  a00;
    logic [SAMPLE_W-1:0]  a01;
    logic [SAMPLE_W-1:0]  a10;
    logic [SAMPLE_W-1:0]  a11;

    // stage 2: column blend products
    logic                 s2_valid_reg;
    logic [PROD_W-1:0]    s2_lo_l_reg;
    logic [PROD_W-1:0]    s2_lo_r_reg;
    logic [PROD_W-1:0]    s2_hi_l_reg;
    logic [PROD_W-1:0]    s2_hi_r_reg;
    logic [WT_W-1:0]      s2_u_reg;
    logic                 s2_clamped_reg;
    logic [SUM_W-1:0]     sum_lo;
    logic [SUM_W-1:0]     sum_hi;

    // stage 3: row results
    logic                 s3_valid_reg;
    logic [SAMPLE_W-1:0]  s3_lo_reg;
    logic [SAMPLE_W-1:0]  s3_hi_reg;
    logic [WT_W-1:0]      s3_u_reg;
    logic                 s3_clamped_reg;

    // stage 4: row blend products
    logic                 s4_valid_reg;
    logic [PROD_W-1:0]    s4_l_reg;
    logic [PROD_W-1:0]    s4_r_reg;
    logic                 s4_clamped_reg;
    logic [SUM_W-1:0]     sum_out;
    bgi_rsp_t             rsp_push;

    // result buffer
    bgi_rsp_t             out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_ptr_reg;
    logic [OUT_PTR_W-1:0] out_rd_ptr_reg;
    logic [OUT_CNT_W-1:0] out_count_reg;
    logic [OUT_CNT_W-1:0] out_count_next;
    logic                 rsp_take;

    // a query is issued only when its result has a reserved buffer slot
    assign op_ready = !op.is_query || (pending_reg < OUT_CNT_W'(OUT_DEPTH));
    assign pop      = op_valid && op_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    // neighbors are columns i-1 and i: one even, one odd
    assign even_col = op.col_idx >> 1;
    assign odd_col  = even_col - IDX_W'(!op.col_idx[0]);
    assign even_row = op.row_idx >> 1;
    assign odd_row  = even_row - IDX_W'(!op.row_idx[0]);
    assign wr_bank  = {op.row_idx[0], op.col_idx[0]};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [IDX_W-1:0]    bank_col;
        logic [IDX_W-1:0]    bank_row;
        logic [BANK_AW-1:0]  bank_addr;
        logic [SAMPLE_W-1:0] bank_mem [BANK_DEPTH];
        logic [SAMPLE_W-1:0] bank_rd_reg;

        assign bank_col  = (op.is_query && (b % 2 == 1)) ? odd_col : even_col;
        assign bank_row  = (op.is_query && (b / 2 == 1)) ? odd_row : even_row;
        assign bank_addr = BANK_AW'(32'(bank_row) * BANK_COLS + 32'(bank_col));

        always_ff @(posedge clk)
        begin
            if (pop && !op.is_query && (wr_bank == 2'(b)))
            begin
                bank_mem[bank_addr] <= op.sample_value;
            end
            if (pop && op.is_query)
            begin
                bank_rd_reg <= bank_mem[bank_addr];
            end
        end

        assign rd_data[b] = bank_rd_reg;
    end

    // sample at column i-1 lives in the bank of the opposite column parity
    assign a00 = rd_data[{~s1_row_par_reg, ~s1_col_par_reg}];
    assign a01 = rd_data[{~s1_row_par_reg,  s1_col_par_reg}];
    assign a10 = rd_data[{ s1_row_par_reg, ~s1_col_par_reg}];
    assign a11 = rd_data[{ s1_row_par_reg,  s1_col_par_reg}];

    assign sum_lo  = SUM_W'(s2_lo_l_reg) + SUM_W'(s2_lo_r_reg) + ROUND_HALF;
    assign sum_hi  = SUM_W'(s2_hi_l_reg) + SUM_W'(s2_hi_r_reg) + ROUND_HALF;
    assign sum_out = SUM_W'(s4_l_reg) + SUM_W'(s4_r_reg) + ROUND_HALF;

    assign rsp_push.interp_value = sum_out[FRAC_BITS +: SAMPLE_W];
    assign rsp_push.edge_clamped = s4_clamped_reg;

    always_comb
    begin
        pending_next = pending_reg;
        if ((pop && op.is_query) && !rsp_take)
        begin
            pending_next = pending_reg + OUT_CNT_W'(1);
        end
        else if (!(pop && op.is_query) && rsp_take)
        begin
            pending_next = pending_reg - OUT_CNT_W'(1);
        end
    end

    always_comb
    begin
        out_count_next = out_count_reg;
        if (s4_valid_reg && !rsp_take)
        begin
            out_count_next = out_count_reg + OUT_CNT_W'(1);
        end
        else if (!s4_valid_reg && rsp_take)
        begin
            out_count_next = out_count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            s1_valid_reg  <= pop && op.is_query;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_count_reg <= out_count_next;
            if (s4_valid_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (rsp_take)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + OUT_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && op.is_query)
        begin
            s1_col_par_reg <= op.col_idx[0];
            s1_row_par_reg <= op.row_idx[0];
            s1_t_reg       <= op.col_frac[WT_W-1:0];
            s1_u_reg       <= op.row_frac[WT_W-1:0];
            s1_clamped_reg <= op.clamped;
        end

        s2_lo_l_reg    <= PROD_W'(a00) * PROD_W'(WT_ONE - s1_t_reg);
        s2_lo_r_reg    <= PROD_W'(a01) * PROD_W'(s1_t_reg);
        s2_hi_l_reg    <= PROD_W'(a10) * PROD_W'(WT_ONE - s1_t_reg);
        s2_hi_r_reg    <= PROD_W'(a11) * PROD_W'(s1_t_reg);
        s2_u_reg       <= s1_u_reg;
        s2_clamped_reg <= s1_clamped_reg;

        s3_lo_reg      <= sum_lo[FRAC_BITS +: SAMPLE_W];
        s3_hi_reg      <= sum_hi[FRAC_BITS +: SAMPLE_W];
        s3_u_reg       <= s2_u_reg;
        s3_clamped_reg <= s2_clamped_reg;

        s4_l_reg       <= PROD_W'(s3_lo_reg) * PROD_W'(WT_ONE - s3_u_reg);
        s4_r_reg       <= PROD_W'(s3_hi_reg) * PROD_W'(s3_u_reg);
        s4_clamped_reg <= s3_clamped_reg;

        if (s4_valid_reg)
        begin
            out_mem_reg[out_wr_ptr_reg] <= rsp_push;
        end
    end

    assign rsp_valid = out_count_reg != '0;
    assign rsp       = out_mem_reg[out_rd_ptr_reg];

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("reserved result slots exceed buffer depth");

    a_buffer_covered: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= pending_reg)
        else $error("buffered results not covered by reservations");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (out_count_reg < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result written into a full buffer");

endmodule

`default_nettype wire

// File: src/bilinear_grid_interpolator.sv
// bilinear grid interpolator: one transaction per cycle sustained, unless responses back up
// and the result buffer has no free slot; the rate is set by the four
// parity-banked sample stores, each read once per query
// reset clears control state and sets grid size to 512 x 256;
// the sample store holds no defined value until written
// depends on bgi_pkg, bgi_front, bgi_queue, bgi_back
`timescale 1ns / 1ps
`default_nettype none

module bilinear_grid_interpolator
    import bgi_pkg::*;
#(
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire bgi_req_t               req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output bgi_rsp_t                    rsp
);

    logic [GRID_W_W-1:0] grid_width_reg;
    logic [GRID_H_W-1:0] grid_height_reg;

    logic    front_valid;
    logic    front_ready;
    bgi_op_t front_op;
    logic    back_valid;
    logic    back_ready;
    bgi_op_t back_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_W_W'(512);
            grid_height_reg <= GRID_H_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_W_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GRID_H_W-1:0];
                default:         ;
            endcase
        end
    end

    bgi_front #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .op_valid    (front_valid),
        .op_ready    (front_ready),
        .op          (front_op)
    );

    bgi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    bgi_back #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (back_valid),
        .op_ready  (back_ready),
        .op        (back_op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking testbench for bilinear_grid_interpolator, with a built-in
// interpolation predictor, a handshake driver and monitor, and random idling and stalls
// depends on bgi_pkg and bilinear_grid_interpolator
`timescale 1ns / 1ps

module tb_top;

    import bgi_pkg::*;

    localparam int unsigned GRID_COLS   = 512;
    localparam int unsigned GRID_ROWS   = 256;
    localparam int unsigned COORD_FRAC  = 8;
    localparam int unsigned FRAC_ONE    = 1 << COORD_FRAC;
    localparam int unsigned STORE_DEPTH = GRID_COLS * GRID_ROWS;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned LONG_STALL   = 300;
    localparam int unsigned ITEM_TARGET  = 1250;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef struct {
        int unsigned idx;
        int unsigned frac;
        bit          clamped;
    } axis_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    bgi_req_t               req = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    bgi_rsp_t               rsp;

    // predictor state, updated at the same edges as the block
    logic [SAMPLE_W-1:0] grid_mem [STORE_DEPTH];
    logic [GRID_W_W-1:0] cfg_width = 10'd512;
    logic [GRID_H_W-1:0] cfg_height = 9'd256;
    bgi_rsp_t            pending_interp [$];

    // stimulus side
    bgi_req_t    req_backlog [$];
    bit          grid_written [STORE_DEPTH];
    int unsigned gen_cols = GRID_COLS;
    int unsigned gen_rows = GRID_ROWS;
    int unsigned items_queued = 0;
    bit          src_idle_on = 1'b0;
    bit          snk_idle_on = 1'b0;
    int unsigned src_gap;
    int unsigned rsp_wait;
    int unsigned long_stalls_asked = 0;
    int unsigned long_stalls_done;
    int unsigned long_stall_left;
    logic        sink_blocked;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    bilinear_grid_interpolator #(
        .MAX_COLS  (GRID_COLS),
        .MAX_ROWS  (GRID_ROWS),
        .FRAC_BITS (COORD_FRAC)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned grid_extent(input int unsigned size, input int unsigned hi);
        if (size < 2)
            return 2;
        if (size > hi)
            return hi;
        return size;
    endfunction

    // integer part is the right/lower neighbor, 1-based
    function automatic axis_t split_coord(input int unsigned pos, input int unsigned extent);
        axis_t a;
        a.idx = pos >> COORD_FRAC;
        a.frac = pos & (FRAC_ONE - 1);
        a.clamped = 1'b0;
        if (a.idx >= extent)
        begin
            a.idx = extent - 1;
            a.frac = FRAC_ONE;
            a.clamped = 1'b1;
        end
        else if (a.idx == 0)
        begin
            a.idx = 1;
            a.frac = 0;
            a.clamped = 1'b1;
        end
        return a;
    endfunction

    function automatic longint unsigned mix_pair(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned w);
        return ((FRAC_ONE - w) * a + w * b + (FRAC_ONE >> 1)) >> COORD_FRAC;
    endfunction

    function automatic longint unsigned sample_at(input int unsigned col, input int unsigned row);
        return grid_mem[row * GRID_COLS + col];
    endfunction

    function automatic bgi_rsp_t interp_predict(input bgi_req_t q);
        axis_t           ax;
        axis_t           ay;
        longint unsigned upper;
        longint unsigned lower;
        longint unsigned mixed;
        bgi_rsp_t        r;
        ax = split_coord(q.x_pos, grid_extent(cfg_width, GRID_COLS));
        ay = split_coord(q.y_pos, grid_extent(cfg_height, GRID_ROWS));
        upper = mix_pair(sample_at(ax.idx - 1, ay.idx - 1), sample_at(ax.idx, ay.idx - 1),
                         ax.frac);
        lower = mix_pair(sample_at(ax.idx - 1, ay.idx), sample_at(ax.idx, ay.idx),
                         ax.frac);
        mixed = mix_pair(upper, lower, ay.frac);
        r.interp_value = mixed[SAMPLE_W-1:0];
        r.edge_clamped = ax.clamped | ay.clamped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 20)
            $display("[%0t] error: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // driver: one transaction per item, then a drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            src_gap <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (src_gap != 0)
            begin
                src_gap <= src_gap - 1;
                req_valid <= 1'b0;
            end
            else if (req_backlog.size() != 0)
            begin
                req <= req_backlog.pop_front();
                req_valid <= 1'b1;
                src_gap <= src_idle_on ? $urandom_range(0, 16) : 0;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_blocked <= 1'b0;
            long_stall_left <= 0;
            long_stalls_done <= 0;
        end
        else if (long_stall_left != 0)
        begin
            long_stall_left <= long_stall_left - 1;
            if (long_stall_left == 1)
                sink_blocked <= 1'b0;
        end
        else if (long_stalls_done != long_stalls_asked)
        begin
            long_stalls_done <= long_stalls_done + 1;
            long_stall_left <= LONG_STALL;
            sink_blocked <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_wait <= 0;
        end
        else
        begin : sink_pace
            int unsigned draw;
            if (rsp_valid && rsp_ready)
            begin
                draw = snk_idle_on ? $urandom_range(0, 16) : 0;
                rsp_wait <= draw;
                rsp_ready <= (draw == 0) && !sink_blocked;
            end
            else if (rsp_wait != 0)
            begin
                rsp_wait <= rsp_wait - 1;
                rsp_ready <= (rsp_wait == 1) && !sink_blocked;
            end
            else
                rsp_ready <= !sink_blocked;
        end
    end

    // monitor: responses checked before this edge's request is applied
    always @(posedge clk)
    begin
        if (rst_n)
        begin : observe
            bgi_rsp_t want;
            if (rsp_valid && rsp_ready)
            begin
                if (pending_interp.size() == 0)
                    report_mismatch("response with no query outstanding", rsp.interp_value, '0);
                else
                begin
                    want = pending_interp.pop_front();
                    if (rsp.interp_value !== want.interp_value)
                        report_mismatch("interp_value", rsp.interp_value, want.interp_value);
                    if (rsp.edge_clamped !== want.edge_clamped)
                        report_mismatch("edge_clamped", rsp.edge_clamped, want.edge_clamped);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    cfg_width = cfg_data[GRID_W_W-1:0];
                else if (cfg_index == REG_GRID_HEIGHT)
                    cfg_height = cfg_data[GRID_H_W-1:0];
            end
            if (req_valid && req_ready)
            begin
                if (req.cmd == CMD_WRITE)
                    grid_mem[req.write_row * GRID_COLS + req.write_col] = req.sample_value;
                else
                    pending_interp.push_back(interp_predict(req));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("error: timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_write(input int unsigned col, input int unsigned row,
                             input logic [SAMPLE_W-1:0] sample);
        bgi_req_t item;
        item.cmd = CMD_WRITE;
        item.x_pos = X_POS_W'($urandom_range(0, 2**X_POS_W - 1));
        item.y_pos = Y_POS_W'($urandom_range(0, 2**Y_POS_W - 1));
        item.write_col = col[COL_W-1:0];
        item.write_row = row[ROW_W-1:0];
        item.sample_value = sample;
        req_backlog.push_back(item);
        grid_written[row * GRID_COLS + col] = 1'b1;
        items_queued++;
    endtask

    // a query is preceded by writes to any of its four neighbors not yet loaded
    task automatic add_query(input int unsigned x, input int unsigned y);
        bgi_req_t    item;
        axis_t       ax;
        axis_t       ay;
        int unsigned c;
        int unsigned r;
        ax = split_coord(x, gen_cols);
        ay = split_coord(y, gen_rows);
        for (int dr = 0; dr < 2; dr++)
        begin
            for (int dc = 0; dc < 2; dc++)
            begin
                c = ax.idx - 1 + dc;
                r = ay.idx - 1 + dr;
                if (!grid_written[r * GRID_COLS + c])
                    add_write(c, r, random_sample());
            end
        end
        item.cmd = CMD_QUERY;
        item.x_pos = x[X_POS_W-1:0];
        item.y_pos = y[Y_POS_W-1:0];
        item.write_col = COL_W'($urandom_range(0, 2**COL_W - 1));
        item.write_row = ROW_W'($urandom_range(0, 2**ROW_W - 1));
        item.sample_value = $urandom;
        req_backlog.push_back(item);
        items_queued++;
    endtask

    task automatic add_random_query();
        int unsigned x_hi;
        int unsigned y_hi;
        int unsigned x;
        int unsigned y;
        // mostly just around the grid in use, including both edges
        x_hi = (gen_cols + 1) * FRAC_ONE - 1;
        y_hi = (gen_rows + 1) * FRAC_ONE - 1;
        if (x_hi > 2**X_POS_W - 1)
            x_hi = 2**X_POS_W - 1;
        if (y_hi > 2**Y_POS_W - 1)
            y_hi = 2**Y_POS_W - 1;
        x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2**X_POS_W - 1)
                                        : $urandom_range(0, x_hi);
        y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2**Y_POS_W - 1)
                                        : $urandom_range(0, y_hi);
        add_query(x, y);
    endtask

    // sampled at the falling edge so every posedge update has settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || pending_interp.size() != 0);
        // trailing writes give no response, so give them time to land
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input int unsigned cols, input int unsigned rows);
        wait_drained();
        write_reg(REG_GRID_WIDTH, cols);
        write_reg(REG_GRID_HEIGHT, rows);
        gen_cols = grid_extent(cols, GRID_COLS);
        gen_rows = grid_extent(rows, GRID_ROWS);
        @(negedge clk);
    endtask

    task automatic run_phase(input int unsigned budget, input bit src_idle,
                             input bit snk_idle, input bit with_hold);
        int unsigned stop_at;
        int unsigned pick;
        src_idle_on = src_idle;
        snk_idle_on = snk_idle;
        if (with_hold)
            long_stalls_asked <= long_stalls_asked + 1;
        stop_at = items_queued + budget;
        while (items_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                add_write($urandom_range(0, gen_cols - 1), $urandom_range(0, gen_rows - 1),
                          random_sample());
            else if (pick < 30)
                add_write($urandom_range(0, GRID_COLS - 1), $urandom_range(0, GRID_ROWS - 1),
                          random_sample());
            else
                add_random_query();
        end
        wait_drained();
    endtask

    initial
    begin
        int unsigned phase_no;
        int unsigned budget;
        bit          hold_now;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // sizes below range give a 2 x 2 grid
        set_grid(0, 1);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        add_write(0, 0, 32'hFFFF_FFFF);
        add_write(1, 0, 32'h0000_0000);
        add_write(0, 1, 32'h1234_5678);
        add_write(1, 1, 32'hFFFF_FFFF);
        add_query(17'h00000, 16'h0000);   // low clamp both axes
        add_query(17'h1FFFF, 16'hFFFF);   // high clamp both axes
        add_query(17'h00180, 16'h0180);   // interior, half weights
        add_query(17'h00100, 16'h0100);   // exactly on a sample
        add_query(17'h001FF, 16'h01FF);   // largest fraction
        add_query(17'h00200, 16'h00FF);   // x lands on the width, y below one
        add_query(17'h000FF, 16'h01C0);   // x below one with a fraction
        wait_drained();

        // sizes above range give the full store
        set_grid(1023, 511);
        add_write(510, 254, 32'h0000_0000);
        add_write(511, 254, 32'hFFFF_FFFF);
        add_write(510, 255, 32'hFFFF_FFFF);
        add_write(511, 255, 32'h0000_0000);
        add_query(17'h1FFFF, 16'hFFFF);
        add_query(17'h1FF80, 16'hFF80);
        add_query(17'h1FE01, 16'hFE7F);
        add_query(17'h00000, 16'h0000);
        wait_drained();

        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            case (phase_no % 6)
                0:
                begin
                    set_grid($urandom_range(0, 16), $urandom_range(0, 16));
                    budget = 150;
                end
                1:
                begin
                    set_grid($urandom_range(17, 64), $urandom_range(17, 64));
                    budget = 100;
                end
                2:
                begin
                    set_grid(2, 2);
                    budget = 150;
                end
                3:
                begin
                    set_grid($urandom_range(3, 16), $urandom_range(3, 16));
                    budget = 150;
                end
                4:
                begin
                    set_grid($urandom_range(65, 1023), $urandom_range(65, 511));
                    budget = 40;
                end
                default:
                begin
                    set_grid(512, 256);
                    budget = 40;
                end
            endcase
            // back up the block with the sender running flat out
            hold_now = (phase_no % 7 == 2);
            run_phase(budget, (phase_no % 4 != 1) && !hold_now, phase_no % 3 != 2, hold_now);
            phase_no++;
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
